@@ rtl/ssd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and the glyph table of the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// item codes
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_CHAR = 1'b1;

	// configuration register indexes
	localparam logic REG_BLINK_ENABLE      = 1'b0;
	localparam logic REG_BLINK_HALF_PERIOD = 1'b1;

	localparam int unsigned CFG_DATA_W       = 16;
	localparam int unsigned ENABLE_W         = 4;
	localparam logic [15:0] HALF_PERIOD_INIT = 16'd250;
	localparam logic [7:0]  CHAR_SPACE       = 8'h20;
	localparam logic [7:0]  CHAR_DOT         = 8'h2E;
	localparam logic [6:0]  GLYPH_BLANK      = 7'h7F;

	typedef struct packed {
		logic       action;
		logic [7:0] char_code;
		logic       string_start;
	} in_item_t;

	typedef struct packed {
		logic [6:0]          segments_n;
		logic                point_n;
		logic [ENABLE_W-1:0] digit_enable_n;
	} out_item_t;

	// one character write toward the digit store
	typedef struct packed {
		logic       write;
		logic       start;
		logic [7:0] code;
	} char_wr_t;

	// active-low glyph, bit0 = a through bit6 = g
	function automatic logic [6:0] glyph_n(input logic [7:0] code);
		logic [7:0] c;
		logic [6:0] g;
		c = code;
		if (c >= 8'h61 && c <= 8'h7A) begin
			c = c - 8'h20;
		end
		case (c)
			8'h30: g = 7'h40;
			8'h31: g = 7'h79;
			8'h32: g = 7'h24;
			8'h33: g = 7'h30;
			8'h34: g = 7'h19;
			8'h35: g = 7'h12;
			8'h36: g = 7'h02;
			8'h37: g = 7'h78;
			8'h38: g = 7'h00;
			8'h39: g = 7'h10;
			8'h2D: g = 7'h3F;
			8'h41: g = 7'h08;
			8'h42: g = 7'h03;
			8'h44: g = 7'h21;
			8'h45: g = 7'h06;
			8'h46: g = 7'h0E;
			8'h48: g = 7'h09;
			8'h4C: g = 7'h47;
			8'h4E: g = 7'h2B;
			8'h4F: g = 7'h40;
			8'h50: g = 7'h0C;
			8'h51: g = 7'h18;
			8'h52: g = 7'h2F;
			8'h54: g = 7'h07;
			8'h55: g = 7'h41;
			8'h59: g = 7'h11;
			8'h27: g = 7'h7D;
			8'h22: g = 7'h5D;
			default: g = GLYPH_BLANK;
		endcase
		return g;
	endfunction

endpackage

@@ rtl/ssd_char_store.sv @@
// ----------------------------------------------------------------------------
// ssd_char_store
// Per-digit character and decimal point store with string write position.
// ----------------------------------------------------------------------------
module ssd_char_store #(
	parameter int DIGITS = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ssd_pkg::char_wr_t                     wr,
	input  logic [(DIGITS > 1 ? $clog2(DIGITS) : 1)-1:0] rd_index,
	output logic [7:0]                            rd_char,
	output logic                                  rd_point
);
	import ssd_pkg::*;

	localparam int SCAN_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int POS_W  = $clog2(DIGITS + 1);

	logic [7:0]       char_q [DIGITS];
	logic [DIGITS-1:0] point_q;
	logic [POS_W-1:0] pos_q;
	logic             ovf_q;

	logic [POS_W-1:0] pos_eff;
	logic             ovf_eff;
	logic             is_dot;
	logic             room;

	assign pos_eff = wr.start ? '0 : pos_q;
	assign ovf_eff = wr.start ? 1'b0 : ovf_q;
	assign is_dot  = (wr.code == CHAR_DOT);
	assign room    = (pos_eff < POS_W'(DIGITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIGITS; k++) begin
				char_q[k] <= CHAR_SPACE;
			end
			point_q <= '0;
			pos_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (wr.write) begin
			if (is_dot) begin
				pos_q <= pos_eff;
				ovf_q <= ovf_eff;
				// dot marks the digit written just before it
				for (int k = 0; k < DIGITS; k++) begin
					if (!ovf_eff && pos_eff == POS_W'(k + 1)) begin
						point_q[k] <= 1'b1;
					end
				end
			end else if (room) begin
				ovf_q <= ovf_eff;
				for (int k = 0; k < DIGITS; k++) begin
					if (pos_eff == POS_W'(k)) begin
						char_q[k]  <= wr.code;
						point_q[k] <= 1'b0;
					end
				end
				pos_q <= pos_eff + 1'b1;
			end else begin
				pos_q <= pos_eff;
				ovf_q <= 1'b1;
			end
		end
	end

	always_comb begin
		rd_char  = CHAR_SPACE;
		rd_point = 1'b0;
		for (int k = 0; k < DIGITS; k++) begin
			if (rd_index == SCAN_W'(k)) begin
				rd_char  = char_q[k];
				rd_point = point_q[k];
			end
		end
	end

endmodule

@@ rtl/seven_segment_scan_driver_unit.sv @@
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit
// Multiplexed seven-segment display driver with blink and decimal points.
// ----------------------------------------------------------------------------
// Usage: the input channel carries character items (action = 1), which fill
// the digit store, and scan tick items (action = 0). Every tick produces one
// result on the output channel: the active-low glyph, decimal point and digit
// enable of the digit being scanned; characters produce no result.
// An accepted item is registered in the input stage, and a tick's result is
// then registered from the input stage into the output register. One item
// can be accepted every cycle while the receiver does not stall; the rate
// is set by the single input stage feeding the output register.
// When the receiver stalls, the output register holds its result and a tick
// waits in the input stage; characters still pass through the input stage
// and in_ready drops only once a tick is blocked there.
// Configuration writes (blink enable, blink half period) take effect at once
// and are expected only while the block is idle.
// Reset clears the store to blanks, the points, the write position, scan and
// blink state, and loads a blink half period of 250.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_unit #(
	parameter int DIGITS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ssd_pkg::in_item_t            in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ssd_pkg::out_item_t           out_item,
	input  logic                         cfg_write_enable,
	input  logic                         cfg_index,
	input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ssd_pkg::*;

	localparam int SCAN_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	// configuration
	logic        blink_enable_q;
	logic [15:0] half_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_enable_q <= 1'b0;
			half_period_q  <= HALF_PERIOD_INIT;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				REG_BLINK_ENABLE:      blink_enable_q <= cfg_data[0];
				REG_BLINK_HALF_PERIOD: half_period_q  <= cfg_data[15:0];
				default:               ;
			endcase
		end
	end

	// input stage
	logic     valid_s1;
	in_item_t item_s1;
	logic     out_free;
	logic     is_tick_s1;
	logic     adv_s1;

	assign out_free   = !out_valid || out_ready;
	assign is_tick_s1 = (item_s1.action == ACT_TICK);
	assign adv_s1     = valid_s1 && (!is_tick_s1 || out_free);
	assign in_ready   = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// digit store
	char_wr_t          wr;
	logic [SCAN_W-1:0] scan_q;
	logic [7:0]        rd_char;
	logic              rd_point;

	assign wr.write = adv_s1 && !is_tick_s1;
	assign wr.start = item_s1.string_start;
	assign wr.code  = item_s1.char_code;

	ssd_char_store #(
		.DIGITS(DIGITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_index (scan_q),
		.rd_char  (rd_char),
		.rd_point (rd_point)
	);

	// blink timer and scan
	logic [15:0]         blink_count_q;
	logic                blink_phase_q;
	logic [15:0]         count_inc;
	logic                phase_hit;
	logic                phase_new;
	logic                tick_go;
	logic [ENABLE_W-1:0] enable_n;
	out_item_t           result;

	assign tick_go   = adv_s1 && is_tick_s1;
	assign count_inc = blink_count_q + 16'd1;
	assign phase_hit = (count_inc == half_period_q);
	assign phase_new = blink_phase_q ^ phase_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_count_q <= '0;
			blink_phase_q <= 1'b0;
			scan_q        <= '0;
		end else if (tick_go) begin
			blink_count_q <= phase_hit ? 16'd0 : count_inc;
			blink_phase_q <= phase_new;
			scan_q        <= (scan_q == SCAN_W'(DIGITS - 1)) ? '0 : scan_q + 1'b1;
		end
	end

	always_comb begin
		enable_n = '1;
		if (!(blink_enable_q && phase_new)) begin
			// only the first four digits have a drive line
			for (int k = 0; k < ENABLE_W; k++) begin
				if (k < DIGITS && scan_q == SCAN_W'(k)) begin
					enable_n[k] = 1'b0;
				end
			end
		end
		result.segments_n     = glyph_n(rd_char);
		result.point_n        = !rd_point;
		result.digit_enable_n = enable_n;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= tick_go;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			out_item <= result;
		end
	end

	// checks
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(~out_item.digit_enable_n))
		else $error("more than one digit driven");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= SCAN_W'(DIGITS - 1))
		else $error("scan index beyond last digit");

	a_tick_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_tick_s1 && !out_free) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled tick lost from input stage");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid)) |-> $past(tick_go))
		else $error("result without a tick");

endmodule
